>>> rtl/itp_pkg.sv
package itp_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int POS_W       = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_TUSER_W = 2;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_MODE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEPARATOR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GROUPING  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SEVEN  = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
  localparam logic [CHAR_W-1:0] SEP_RESET = 8'd44;

  localparam logic [POS_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        base_mode;
    logic [CHAR_W-1:0] separator_char;
    logic              grouping_enabled;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              stream_end;
  } item_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [VALUE_W-1:0] acc;
    logic               any_digit;
    logic [POS_W-1:0]   char_count;
    logic [POS_W-1:0]   start_pos;
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] parsed_value;
    logic               fail_flag;
    logic [POS_W-1:0]   stop_position;
    logic [CHAR_W-1:0]  stop_char;
    logic               ended_by_stream;
  } result_t;

endpackage

>>> rtl/integer_text_parser_core.sv
// Parses one unsigned integer from a character stream in decimal, octal or hex
// (cfg register base_mode), skipping leading spaces, an optional 0x/0X prefix in
// hex and, in decimal with grouping on, the separator character. One character
// item is taken per clock unless stalled as below; a result item becomes valid
// when the character or end-of-stream item that closes the number has been
// accepted into the input register and the step logic, which it feeds, has
// loaded the result register. While a result waits on out_tready, the next item
// that closes a number holds in the input register and stalls the input. That
// rate is set by the step logic, whose single 64-bit multiply-by-base and add
// updates the accumulator once per character. The closing character is reported
// in stop_char and is not part of the next number. Write configuration only
// while no parse is in progress.
module integer_text_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [itp_pkg::CHAR_W-1:0]         in_tdata,   // char_code
  input  logic                               in_tlast,   // stream_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // parsed_value, stop_position, stop_char
  output logic [itp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // fail_flag, ended_by_stream
  output logic [itp_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                               cfg_we,
  input  logic [itp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [itp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import itp_pkg::*;

  cfg_t    cfg_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  state_t  st_r;
  state_t  st_nxt;
  logic    out_valid_r;
  result_t out_res_r;
  logic    step_res_valid;
  result_t step_res;
  logic    s1_fire;
  logic    in_accept;

  itp_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .item      (s1_item_r),
    .st_nxt    (st_nxt),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  assign s1_fire   = s1_valid_r && (!step_res_valid || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_mode        <= BASE_DEC;
      cfg_r.separator_char   <= SEP_RESET;
      cfg_r.grouping_enabled <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BASE_MODE: cfg_r.base_mode        <= cfg_wdata[1:0];
        CFG_SEPARATOR: cfg_r.separator_char   <= cfg_wdata;
        CFG_GROUPING:  cfg_r.grouping_enabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.char_code  <= in_tdata;
      s1_item_r.stream_end <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_SKIP;
      st_r.acc        <= '0;
      st_r.any_digit  <= 1'b0;
      st_r.char_count <= '0;
      st_r.start_pos  <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && step_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_res_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.stop_char, out_res_r.stop_position, out_res_r.parsed_value};
  assign out_tuser  = {out_res_r.ended_by_stream, out_res_r.fail_flag};

`ifndef SYNTHESIS
  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fail_flag |-> out_res_r.parsed_value == '0)
    else $error("failed parse carries a nonzero value");

  a_stream_end_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.ended_by_stream |-> out_res_r.stop_char == '0)
    else $error("stream end result carries a stop character");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && step_res_valid |=> st_r.phase == PH_SKIP && st_r.char_count == '0
      && !st_r.any_digit)
    else $error("parse state not cleared after a result");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_fire && step_res_valid))
    else $error("pending result overwritten");
`endif

endmodule

>>> rtl/itp_step.sv
module itp_step (
  input  itp_pkg::cfg_t    cfg,
  input  itp_pkg::state_t  st,
  input  itp_pkg::item_t   item,
  output itp_pkg::state_t  st_nxt,
  output logic             res_valid,
  output itp_pkg::result_t res
);
  import itp_pkg::*;

  logic               is_hex;
  logic               is_oct;
  logic               is_dec;
  logic [CHAR_W-1:0]  ch;
  logic [POS_W-1:0]   cnt_inc;
  logic [3:0]         dig_val;
  logic               dig_ok;
  logic [VALUE_W-1:0] acc_mul;
  logic [VALUE_W-1:0] acc_new;
  logic               go_common;
  logic               fin;
  logic [POS_W-1:0]   start_eff;

  assign ch     = item.char_code;
  assign is_hex = (cfg.base_mode == BASE_HEX);
  assign is_oct = (cfg.base_mode == BASE_OCT);
  assign is_dec = !is_hex && !is_oct;

  assign cnt_inc = (st.char_count == COUNT_MAX) ? st.char_count : st.char_count + 16'd1;

  // digit decode for the active base
  always_comb begin
    dig_val = ch[3:0];
    dig_ok  = 1'b0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      dig_ok = is_oct ? (ch <= CH_SEVEN) : 1'b1;
    end else if (is_hex && ((ch >= CH_LOW_A && ch <= CH_LOW_F) ||
                            (ch >= CH_UP_A && ch <= CH_UP_F))) begin
      dig_val = ch[3:0] + 4'd9;
      dig_ok  = 1'b1;
    end
  end

  // multiply by base as shifts, plus one add in decimal
  always_comb begin
    if (is_hex) begin
      acc_mul = {st.acc[VALUE_W-5:0], 4'b0};
    end else if (is_oct) begin
      acc_mul = {st.acc[VALUE_W-4:0], 3'b0};
    end else begin
      acc_mul = {st.acc[VALUE_W-4:0], 3'b0} + {st.acc[VALUE_W-2:0], 1'b0};
    end
  end

  assign acc_new = acc_mul + {{(VALUE_W-4){1'b0}}, dig_val};

  always_comb begin
    st_nxt    = st;
    go_common = 1'b0;
    fin       = 1'b0;
    start_eff = st.start_pos;
    unique case (st.phase)
      PH_SKIP: begin
        start_eff = st.char_count;
        if (item.stream_end) begin
          fin = 1'b1;
        end else if (ch == CH_SPACE) begin
          st_nxt.char_count = cnt_inc;
        end else begin
          st_nxt.start_pos = st.char_count;
          if (ch == CH_ZERO && !is_dec) begin
            st_nxt.char_count = cnt_inc;
            st_nxt.any_digit  = 1'b1;
            st_nxt.acc        = '0;
            st_nxt.phase      = is_hex ? PH_ZERO : PH_DIGITS;
          end else begin
            st_nxt.phase = PH_DIGITS;
            go_common    = 1'b1;
          end
        end
      end
      PH_ZERO: begin
        if (item.stream_end) begin
          fin = 1'b1;
        end else begin
          st_nxt.phase = PH_DIGITS;
          if (ch == CH_LOW_X || ch == CH_UP_X) begin
            // 0x prefix: restart after it
            st_nxt.char_count = cnt_inc;
            st_nxt.start_pos  = cnt_inc;
            st_nxt.any_digit  = 1'b0;
          end else begin
            go_common = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        go_common = 1'b1;
      end
      default: begin
        st_nxt.phase = PH_DIGITS;
        go_common    = 1'b1;
      end
    endcase

    if (go_common) begin
      if (item.stream_end) begin
        fin = 1'b1;
      end else if (cfg.grouping_enabled && is_dec && ch == cfg.separator_char) begin
        st_nxt.char_count = cnt_inc;
      end else if (!dig_ok) begin
        fin = 1'b1;
      end else begin
        st_nxt.acc        = acc_new;
        st_nxt.any_digit  = 1'b1;
        st_nxt.char_count = cnt_inc;
      end
    end

    res_valid           = fin;
    res.parsed_value    = st.any_digit ? st.acc : '0;
    res.fail_flag       = !st.any_digit;
    res.stop_position   = st.any_digit ? st.char_count : start_eff;
    res.stop_char       = item.stream_end ? '0 : ch;
    res.ended_by_stream = item.stream_end;

    if (fin) begin
      st_nxt.phase      = PH_SKIP;
      st_nxt.acc        = '0;
      st_nxt.any_digit  = 1'b0;
      st_nxt.char_count = '0;
      st_nxt.start_pos  = '0;
    end
  end

endmodule
